>>> hdl/yfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 frame rotator package
// Shared sizes, configuration view and the command that travels from the
// address front end to the frame bank back end.
// ----------------------------------------------------------------------------
package yfr_pkg;

    // Largest supported luma frame.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // Bytes of one frame bank: luma plus two quarter-size chroma planes.
    localparam int BANK_BYTES = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;

    // Byte offset inside one bank.
    localparam int POS_W = $clog2(BANK_BYTES);

    // Frame dimension registers hold values up to the maximum itself.
    localparam int DIM_W = 9;

    // Output column and row counters.
    localparam int COORD_W = 8;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;

    // Rotation codes.
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_90   = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_270  = 2'd3;

    // Plane codes.
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Frame geometry as the front end uses it, derived when a register is written.
    typedef struct packed {
        logic [1:0]       rotation;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [POS_W-1:0] luma_bytes;
        logic [POS_W-1:0] total_bytes;
        logic [POS_W-1:0] v_base;
    } yfr_cfg_t;

    // One memory operation pair: store the incoming byte, fetch the rotated byte.
    typedef struct packed {
        logic             wr_bank;
        logic [POS_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [POS_W-1:0] rd_addr;
        logic             have_prev;
        logic             last;
    } yfr_cmd_t;

    // Drop bit 0 and saturate into 2..maxv.
    function automatic logic [DIM_W-1:0] even_clamp(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] r;
        m = {maxv[DIM_W-1:1], 1'b0};
        r = {v[DIM_W-1:1], 1'b0};
        if (r < DIM_W'(2)) begin
            r = DIM_W'(2);
        end
        if (r > m) begin
            r = m;
        end
        return r;
    endfunction

endpackage

>>> hdl/yuv420_frame_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 frame rotator
// Streams planar YUV 4:2:0 frames into a double-buffered frame store and
// returns the previous frame rotated by 0, 90, 180 or 270 degrees.
// ----------------------------------------------------------------------------
// One byte is taken and one result byte returned per clock in sustained
// operation while the output is not stalled; the frame store sets that rate
// with one write into the current bank and one read from the other bank per
// cycle. A result passes from its input through the command queue, the read
// stage and the output register; the four-entry queue and the output
// register absorb stalls so input keeps flowing while a result waits. Results
// of the first frame carry out_valid low and a zero sample. The frame store
// is not cleared after reset. Width, height and rotation are to be written
// through the register port while the block is idle, which the block does
// not enforce; width and height are forced even and saturated into 2..256.
// ----------------------------------------------------------------------------
module yuv420_frame_rotator import yfr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input byte channel
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [7:0]  pixel_in,
    // Rotated result channel
    output logic        rot_valid,
    input  logic        rot_stall,
    output logic [7:0]  pixel_out,
    output logic        out_valid,
    output logic        frame_last
);

    localparam logic [DIM_W-1:0] DIM_MAX_W   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H   = DIM_W'(MAX_HEIGHT);
    localparam logic [POS_W-1:0] RESET_LUMA  = POS_W'(MAX_WIDTH * MAX_HEIGHT);
    localparam logic [POS_W-1:0] RESET_TOTAL = POS_W'((MAX_WIDTH * MAX_HEIGHT * 3) / 2);
    localparam logic [POS_W-1:0] RESET_VBASE = POS_W'((MAX_WIDTH * MAX_HEIGHT * 5) / 4);

    logic [1:0]       rotation_reg, rotation_next;
    logic [DIM_W-1:0] raw_width_reg, raw_width_next;
    logic [DIM_W-1:0] raw_height_reg, raw_height_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [POS_W-1:0] luma_reg, luma_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [POS_W-1:0] vbase_reg, vbase_next;
    logic [2*DIM_W-1:0] area;

    logic       cfg_write;
    logic [1:0] reg_index;

    yfr_cfg_t cfg;
    yfr_cmd_t front_cmd;
    yfr_cmd_t back_cmd;
    logic     queue_full;
    logic     queue_not_empty;
    logic     queue_pop;
    logic     in_accept;

    // Register port decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        case (reg_index)
            REG_ROTATION: prdata = {30'd0, rotation_reg};
            REG_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, raw_width_reg};
            REG_HEIGHT:   prdata = {{(32-DIM_W){1'b0}}, raw_height_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Register writes; frame geometry is derived at the same edge.
    always_comb
    begin
        rotation_next   = rotation_reg;
        raw_width_next  = raw_width_reg;
        raw_height_next = raw_height_reg;
        if (cfg_write) begin
            case (reg_index)
                REG_ROTATION: rotation_next   = pwdata[1:0];
                REG_WIDTH:    raw_width_next  = pwdata[DIM_W-1:0];
                REG_HEIGHT:   raw_height_next = pwdata[DIM_W-1:0];
                default:      rotation_next   = rotation_reg;
            endcase
        end
        width_next  = even_clamp(raw_width_next, DIM_MAX_W);
        height_next = even_clamp(raw_height_next, DIM_MAX_H);
        area        = width_next * height_next;
        luma_next   = area[POS_W-1:0];
        total_next  = luma_next + {1'b0, luma_next[POS_W-1:1]};
        vbase_next  = luma_next + {2'b00, luma_next[POS_W-1:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rotation_reg   <= ROT_NONE;
            raw_width_reg  <= DIM_MAX_W;
            raw_height_reg <= DIM_MAX_H;
            width_reg      <= DIM_MAX_W;
            height_reg     <= DIM_MAX_H;
            luma_reg       <= RESET_LUMA;
            total_reg      <= RESET_TOTAL;
            vbase_reg      <= RESET_VBASE;
        end else begin
            rotation_reg   <= rotation_next;
            raw_width_reg  <= raw_width_next;
            raw_height_reg <= raw_height_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            luma_reg       <= luma_next;
            total_reg      <= total_next;
            vbase_reg      <= vbase_next;
        end
    end

    always_comb
    begin
        cfg.rotation    = rotation_reg;
        cfg.width       = width_reg;
        cfg.height      = height_reg;
        cfg.luma_bytes  = luma_reg;
        cfg.total_bytes = total_reg;
        cfg.v_base      = vbase_reg;
    end

    // Input transfer is taken whenever the queue has room.
    assign pix_stall = queue_full;
    assign in_accept = pix_valid && !queue_full;

    yfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (in_accept),
        .pixel_in (pixel_in),
        .cmd      (front_cmd)
    );

    yfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_cmd   (back_cmd),
        .not_empty (queue_not_empty)
    );

    yfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_not_empty),
        .cmd        (back_cmd),
        .cmd_pop    (queue_pop),
        .rot_valid  (rot_valid),
        .rot_stall  (rot_stall),
        .pixel_out  (pixel_out),
        .out_valid  (out_valid),
        .frame_last (frame_last)
    );

endmodule

>>> hdl/yfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 frame rotator front end
// Accepts input bytes, tracks write position and output raster position per
// plane, and turns each transfer into a write and a rotated read address.
// ----------------------------------------------------------------------------
module yfr_front import yfr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  yfr_cfg_t cfg,
    input  logic     accept,
    input  logic [7:0] pixel_in,
    output yfr_cmd_t cmd
);

    logic               write_bank_reg, write_bank_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [1:0]         plane_reg, plane_next;
    logic               have_prev_reg, have_prev_next;

    logic [1:0]         plane;
    logic [DIM_W-1:0]   in_w, in_h, out_w, out_h;
    logic [DIM_W-1:0]   ow_m1, oh_m1;
    logic [COORD_W-1:0] x, y;
    logic [DIM_W-1:0]   iw_m1_x, ih_m1_x, ih_m1_y, iw_m1_y;
    logic [COORD_W-1:0] mul_term, add_term;
    logic [POS_W-1:0]   base;
    logic [DIM_W+COORD_W-1:0] product;
    logic [POS_W-1:0]   src;
    logic [POS_W:0]     pos_inc;
    logic               last;
    logic [DIM_W-1:0]   col_inc, row_inc;

    // Current plane geometry, input and output side.
    always_comb
    begin
        plane = (plane_reg == 2'd3) ? PLANE_V : plane_reg;
        if (plane == PLANE_Y) begin
            in_w = cfg.width;
            in_h = cfg.height;
        end else begin
            in_w = {1'b0, cfg.width[DIM_W-1:1]};
            in_h = {1'b0, cfg.height[DIM_W-1:1]};
        end
        case (plane)
            PLANE_Y: base = '0;
            PLANE_U: base = cfg.luma_bytes;
            default: base = cfg.v_base;
        endcase
        if (cfg.rotation[0]) begin
            out_w = in_h;
            out_h = in_w;
        end else begin
            out_w = in_w;
            out_h = in_h;
        end
        ow_m1 = out_w - DIM_W'(1);
        oh_m1 = out_h - DIM_W'(1);
    end

    // Output coordinates, held to the plane edge if the frame shrank under them.
    always_comb
    begin
        x = ({1'b0, col_reg} < out_w) ? col_reg : ow_m1[COORD_W-1:0];
        y = ({1'b0, row_reg} < out_h) ? row_reg : oh_m1[COORD_W-1:0];
        iw_m1_x = in_w - DIM_W'(1) - {1'b0, x};
        ih_m1_x = in_h - DIM_W'(1) - {1'b0, x};
        ih_m1_y = in_h - DIM_W'(1) - {1'b0, y};
        iw_m1_y = in_w - DIM_W'(1) - {1'b0, y};
    end

    // Source offset is in_w * row_term + column_term inside the plane.
    always_comb
    begin
        case (cfg.rotation)
            ROT_NONE:
            begin
                mul_term = y;
                add_term = x;
            end
            ROT_90:
            begin
                mul_term = ih_m1_x[COORD_W-1:0];
                add_term = y;
            end
            ROT_180:
            begin
                mul_term = ih_m1_y[COORD_W-1:0];
                add_term = iw_m1_x[COORD_W-1:0];
            end
            default:
            begin
                mul_term = x;
                add_term = iw_m1_y[COORD_W-1:0];
            end
        endcase
        product = in_w * mul_term;
        src = product[POS_W-1:0] + POS_W'(add_term) + base;
    end

    // End of frame when the next position reaches the frame size.
    assign pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign last    = (pos_inc >= {1'b0, cfg.total_bytes});
    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);

    // Position counters advance on each accepted transfer.
    always_comb
    begin
        write_bank_next = write_bank_reg;
        pos_next        = pos_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        have_prev_next  = have_prev_reg;
        if (accept) begin
            if (last) begin
                pos_next        = '0;
                col_next        = '0;
                row_next        = '0;
                plane_next      = PLANE_Y;
                write_bank_next = ~write_bank_reg;
                have_prev_next  = 1'b1;
            end else begin
                pos_next = pos_inc[POS_W-1:0];
                if (col_inc >= out_w) begin
                    col_next = '0;
                    if (row_inc >= out_h) begin
                        row_next   = '0;
                        plane_next = (plane_reg >= PLANE_V) ? PLANE_Y : plane_reg + 2'd1;
                    end else begin
                        row_next = row_inc[COORD_W-1:0];
                    end
                end else begin
                    col_next = col_inc[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            write_bank_reg <= 1'b0;
            pos_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            plane_reg      <= PLANE_Y;
            have_prev_reg  <= 1'b0;
        end else begin
            write_bank_reg <= write_bank_next;
            pos_reg        <= pos_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            plane_reg      <= plane_next;
            have_prev_reg  <= have_prev_next;
        end
    end

    // Command for the back end.
    always_comb
    begin
        cmd.wr_bank   = write_bank_reg;
        cmd.wr_addr   = pos_reg;
        cmd.wr_data   = pixel_in;
        cmd.rd_addr   = src;
        cmd.have_prev = have_prev_reg;
        cmd.last      = last;
    end

endmodule

>>> hdl/yfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 frame rotator command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module yfr_queue import yfr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  yfr_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output yfr_cmd_t pop_cmd,
    output logic     not_empty
);

    yfr_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/yfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 frame rotator back end
// Holds the two frame banks, performs the write and the rotated read of each
// command, and presents results through an output register.
// ----------------------------------------------------------------------------
module yfr_back import yfr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  yfr_cmd_t   cmd,
    output logic       cmd_pop,
    output logic       rot_valid,
    input  logic       rot_stall,
    output logic [7:0] pixel_out,
    output logic       out_valid,
    output logic       frame_last
);

    logic [7:0] bank0_mem [BANK_BYTES];
    logic [7:0] bank1_mem [BANK_BYTES];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_bank_reg;
    logic       s1_prev_reg;
    logic       s1_last_reg;

    logic       ov_reg, ov_next;
    logic [7:0] pix_reg;
    logic       prev_reg;
    logic       last_reg;

    logic       out_free;
    logic [7:0] sample;

    // Handshake through the read stage and the output register.
    assign out_free = !ov_reg || !rot_stall;
    assign cmd_pop  = cmd_valid && (!s1_valid_reg || out_free);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_pop) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
        ov_next = out_free ? s1_valid_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            ov_reg       <= ov_next;
        end
    end

    // Frame banks: one bank is written while the other is read.
    always_ff @(posedge clk)
    begin
        if (cmd_pop) begin
            if (cmd.wr_bank) begin
                bank1_mem[cmd.wr_addr] <= cmd.wr_data;
            end else begin
                bank0_mem[cmd.wr_addr] <= cmd.wr_data;
            end
            rd0_reg <= bank0_mem[cmd.rd_addr];
            rd1_reg <= bank1_mem[cmd.rd_addr];
        end
    end

    // Read stage side information.
    always_ff @(posedge clk)
    begin
        if (cmd_pop) begin
            s1_bank_reg <= ~cmd.wr_bank;
            s1_prev_reg <= cmd.have_prev;
            s1_last_reg <= cmd.last;
        end
    end

    // Output register; the sample reads as zero until a frame is stored.
    assign sample = s1_bank_reg ? rd1_reg : rd0_reg;

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            pix_reg  <= s1_prev_reg ? sample : 8'd0;
            prev_reg <= s1_prev_reg;
            last_reg <= s1_last_reg;
        end
    end

    assign rot_valid  = ov_reg;
    assign pixel_out  = pix_reg;
    assign out_valid  = prev_reg;
    assign frame_last = last_reg;

endmodule
